// ===== hw/rtl/a32up_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a32up_pkg
// Shared types and constants for the ARGB32 unpremultiply pipeline.
// ----------------------------------------------------------------------------
package a32up_pkg;

  localparam int unsigned NUM_CHAN       = 3;   // red, green, blue
  localparam int unsigned BITS_PER_STAGE = 2;   // quotient bits per divider stage
  localparam int unsigned QUO_W          = 8;
  localparam int unsigned NUM_W          = 16;  // c*255 + a/2 fits in 16 bits
  localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;
  localparam int unsigned PIPE_DEPTH     = DIV_STAGES + 1;  // prep stage + divider

  localparam logic [7:0] BYTE_MAX = 8'hFF;

  // Channel order inside the stage record
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  typedef struct packed {
    logic [NUM_CHAN-1:0][NUM_W-1:0] rem;       // running remainder
    logic [NUM_CHAN-1:0][QUO_W-1:0] quo;       // quotient bits built so far
    logic [NUM_CHAN-1:0]            skip;      // result already final
    logic [7:0]                     alpha;     // divisor
    logic [7:0]                     alpha_out;
    logic                           last;
  } stage_t;

endpackage

// ===== hw/rtl/argb32_unpremultiply_to_rgba.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb32_unpremultiply_to_rgba
// Premultiplied ARGB32 pixel stream to straight R, G, B, A bytes.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one premultiplied pixel per request, tdata = A[31:24] R G B[7:0],
//           tlast marks the final pixel of the image.
//   m_axis: one result per pixel, tdata = red[7:0], green[15:8], blue[23:16],
//           alpha[31:24]; tlast copies the input mark.
//   cfg:    cfg_we_i writes cfg_wdata_i into keep_alpha (reset value 1).
//           keep_alpha = 1: each colour c -> round(c*255/alpha), saturated to
//           255 when c > alpha, zero for zero alpha; alpha passes through.
//           keep_alpha = 0: colours copied, alpha output zero.
//           Write it only while the pipe is empty; each pixel samples it on entry.
// Timing
//   Five register stages: one prep stage (numerator, saturation and bypass
//   decisions) and four divider stages, each resolving two quotient bits of
//   all three channels by restoring long division. Throughput is one pixel
//   per cycle while the receiver is not stalling.
// Reset and stall
//   Reset empties the pipe and sets keep_alpha. Each stage holds its contents
//   while the one after it is full and stalled, so a stalled receiver backs the
//   pipe up stage by stage; bubbles close up, and s_axis_tready_o drops only
//   when all five stages hold a pixel.
// ----------------------------------------------------------------------------
module argb32_unpremultiply_to_rgba
  import a32up_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // keep_alpha
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // pixel_word
  input  logic        s_axis_tlast_i,   // last_pixel
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // red_out, green_out, blue_out, alpha_out
  output logic        m_axis_tlast_o    // last_out
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic keep_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_alpha_q <= 1'b1;
    end else if (cfg_we_i) begin
      keep_alpha_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage may load when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic   [PIPE_DEPTH-1:0] vld_q;
  logic   [PIPE_DEPTH:0]   rdy;
  stage_t                  stg_q [PIPE_DEPTH];
  stage_t                  stg_d [PIPE_DEPTH];

  assign rdy[PIPE_DEPTH] = m_axis_tready_i;

  for (genvar gs = 0; gs < PIPE_DEPTH; gs++) begin : g_ctrl
    assign rdy[gs] = !vld_q[gs] || rdy[gs+1];
  end

  assign s_axis_tready_o = rdy[0];

  // --------------------------------------------------------------------------
  // Prep stage: unpack, build rounded numerator c*255 + a/2, decide bypass
  // --------------------------------------------------------------------------
  logic [7:0] in_alpha;
  logic [NUM_CHAN-1:0][7:0] in_col;

  assign in_alpha        = s_axis_tdata_i[31:24];
  assign in_col[CH_RED]   = s_axis_tdata_i[23:16];
  assign in_col[CH_GREEN] = s_axis_tdata_i[15:8];
  assign in_col[CH_BLUE]  = s_axis_tdata_i[7:0];

  always_comb begin
    stg_d[0] = '0;
    stg_d[0].alpha     = in_alpha;
    stg_d[0].alpha_out = keep_alpha_q ? in_alpha : 8'h00;
    stg_d[0].last      = s_axis_tlast_i;
    for (int c = 0; c < NUM_CHAN; c++) begin
      stg_d[0].rem[c] = {in_col[c], 8'h00} - {8'h00, in_col[c]}
                        + {9'h000, in_alpha[7:1]};
      if (!keep_alpha_q) begin
        stg_d[0].skip[c] = 1'b1;          // copy mode
        stg_d[0].quo[c]  = in_col[c];
      end else if (in_alpha == 8'h00) begin
        stg_d[0].skip[c] = 1'b1;          // transparent pixel gives black
        stg_d[0].quo[c]  = 8'h00;
      end else if (in_col[c] > in_alpha) begin
        stg_d[0].skip[c] = 1'b1;          // malformed: quotient would pass 255
        stg_d[0].quo[c]  = BYTE_MAX;
      end else begin
        // c <= a keeps the numerator below 256*a, so 8 quotient bits suffice
        stg_d[0].skip[c] = 1'b0;
        stg_d[0].quo[c]  = 8'h00;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: two restoring steps per stage, MSB first
  // --------------------------------------------------------------------------
  for (genvar gs = 1; gs < PIPE_DEPTH; gs++) begin : g_div
    localparam int unsigned TOP_BIT = QUO_W - 1 - (gs - 1) * BITS_PER_STAGE;

    always_comb begin
      logic [NUM_W-1:0] dvs;
      int unsigned      bit_pos;
      stg_d[gs] = stg_q[gs-1];
      for (int c = 0; c < NUM_CHAN; c++) begin
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
          bit_pos = TOP_BIT - k;
          dvs     = {8'h00, stg_q[gs-1].alpha} << bit_pos;
          if (!stg_q[gs-1].skip[c] && (stg_d[gs].rem[c] >= dvs)) begin
            stg_d[gs].rem[c]          = stg_d[gs].rem[c] - dvs;
            stg_d[gs].quo[c][bit_pos] = 1'b1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage registers
  // --------------------------------------------------------------------------
  for (genvar gs = 0; gs < PIPE_DEPTH; gs++) begin : g_reg
    logic prev_vld;

    if (gs == 0) begin : g_first
      assign prev_vld = s_axis_tvalid_i;
    end else begin : g_rest
      assign prev_vld = vld_q[gs-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[gs] <= 1'b0;
      end else if (rdy[gs]) begin
        vld_q[gs] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[gs] && prev_vld) begin
        stg_q[gs] <= stg_d[gs];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output
  // --------------------------------------------------------------------------
  assign m_axis_tvalid_o = vld_q[PIPE_DEPTH-1];
  assign m_axis_tdata_o  = {stg_q[PIPE_DEPTH-1].alpha_out,
                            stg_q[PIPE_DEPTH-1].quo[CH_BLUE],
                            stg_q[PIPE_DEPTH-1].quo[CH_GREEN],
                            stg_q[PIPE_DEPTH-1].quo[CH_RED]};
  assign m_axis_tlast_o  = stg_q[PIPE_DEPTH-1].last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // Input is refused only when every stage is occupied
  a_full_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&vld_q))
    else $error("input stalled with an empty pipeline stage");

  // The full prep stage keeps its pixel while its successor is stalled
  a_first_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !rdy[1]) |=> (vld_q[0] && $stable(stg_q[0])))
    else $error("prep stage lost or changed a held pixel");

  // Finished division leaves a remainder below the divisor
  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((stg_q[PIPE_DEPTH-1].skip[CH_RED] ||
        stg_q[PIPE_DEPTH-1].rem[CH_RED] < {8'h00, stg_q[PIPE_DEPTH-1].alpha}) &&
       (stg_q[PIPE_DEPTH-1].skip[CH_GREEN] ||
        stg_q[PIPE_DEPTH-1].rem[CH_GREEN] < {8'h00, stg_q[PIPE_DEPTH-1].alpha}) &&
       (stg_q[PIPE_DEPTH-1].skip[CH_BLUE] ||
        stg_q[PIPE_DEPTH-1].rem[CH_BLUE] < {8'h00, stg_q[PIPE_DEPTH-1].alpha})))
    else $error("divider remainder not reduced below alpha");
`endif

endmodule

// ===== tb/argb32_unpremultiply_to_rgba_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb32_unpremultiply_to_rgba_tb
// Self-checking regression for the premultiplied ARGB32 to RGBA pipeline.
// ----------------------------------------------------------------------------
// Pixels are queued by the stimulus process and fed to s_axis by a clocked
// driver that sends in random bursts. Each accepted pixel is run through a
// local unpremultiply predictor, and the expected RGBA result is queued. A
// clocked monitor takes results from m_axis under a changing stall pattern
// and compares every field against the oldest expectation. keep_alpha is
// switched between phases, only once the pipe has drained. One phase holds
// m_axis off for a long stretch so the pipe fills and backs up s_axis.
// ----------------------------------------------------------------------------
module argb32_unpremultiply_to_rgba_tb
  import a32up_pkg::*;
();

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned LONG_STALL   = 200;   // receiver hold-off, cycles
  localparam int unsigned MAX_PRINTS   = 30;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } rgba_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_FULL,     // always ready
    RX_HALF,     // coin toss each cycle
    RX_SPARSE,   // ready about one cycle in four
    RX_MOSTLY    // stalls about one cycle in eight
  } rx_mode_e;

  // DUT ports; the inputs are all known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_wdata_i     = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // stimulus / scoreboard state
  pix_req_t    pixel_pending_q[$];
  rgba_t       rgba_expect_q[$];
  logic        keep_alpha_mirror = 1'b1;   // reset value of the register
  int unsigned n_queued  = 0;
  int unsigned n_checked = 0;
  int unsigned err_count = 0;

  // sender burst shaping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // receiver pattern and long hold-off
  rx_mode_e    rx_mode    = RX_FULL;
  int unsigned mode_left  = 0;
  logic        pressure_on = 1'b0;
  logic        stall_done  = 1'b0;
  int unsigned stall_cnt   = 0;
  logic        rx_hold;

  assign rx_hold = pressure_on && !stall_done;

  argb32_unpremultiply_to_rgba dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Rounded c*255/a; zero alpha gives black, c > a saturates at 255.
  function automatic logic [7:0] unpremul_chan(logic [7:0] c, logic [7:0] a);
    int unsigned q;
    if (a == 8'd0) return 8'd0;
    q = ({24'd0, c} * 32'd255 + {25'd0, a[7:1]}) / {24'd0, a};
    if (q > 32'd255) return BYTE_MAX;
    return q[7:0];
  endfunction

  function automatic rgba_t predict_rgba(pix_req_t px, logic keep);
    rgba_t      res;
    logic [7:0] a;
    a = px.word[31:24];
    if (keep) begin
      res.red   = unpremul_chan(px.word[23:16], a);
      res.green = unpremul_chan(px.word[15:8], a);
      res.blue  = unpremul_chan(px.word[7:0], a);
      res.alpha = a;
    end else begin
      // mode clear: straight copy, alpha forced to zero
      res.red   = px.word[23:16];
      res.green = px.word[15:8];
      res.blue  = px.word[7:0];
      res.alpha = 8'd0;
    end
    res.last = px.last;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps; gaps vanish under pressure.
  // The expectation is formed at the accepting edge with the current mode.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pix_req_t nxt;
    logic     drive;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      drive = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        nxt.word = s_axis_tdata_i;
        nxt.last = s_axis_tlast_i;
        rgba_expect_q.push_back(predict_rgba(nxt, keep_alpha_mirror));
        drive = 1'b0;
      end
      if (!drive) begin
        if (gap_left > 0 && !pressure_on) begin
          gap_left--;
        end else if (pixel_pending_q.size() > 0) begin
          nxt = pixel_pending_q.pop_front();
          s_axis_tdata_i <= nxt.word;
          s_axis_tlast_i <= nxt.last;
          drive = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      s_axis_tvalid_i <= drive;
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here, armed once by the pressure phase.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (pressure_on && !stall_done) begin
      if (stall_cnt == LONG_STALL - 1) stall_done <= 1'b1;
      stall_cnt <= stall_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result, then pick next cycle's tready.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rgba_t got;
    rgba_t want;
    logic  rdy;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.red   = m_axis_tdata_o[7:0];
      got.green = m_axis_tdata_o[15:8];
      got.blue  = m_axis_tdata_o[23:16];
      got.alpha = m_axis_tdata_o[31:24];
      got.last  = m_axis_tlast_o;
      if (rgba_expect_q.size() == 0) begin
        report_mismatch($sformatf("result %h/%b with no pixel pending",
                                  m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        want = rgba_expect_q.pop_front();
        n_checked++;
        if (got !== want)
          report_mismatch($sformatf(
            "got r=%h g=%h b=%h a=%h last=%b, want r=%h g=%h b=%h a=%h last=%b",
            got.red, got.green, got.blue, got.alpha, got.last,
            want.red, want.green, want.blue, want.alpha, want.last));
      end
    end

    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'(2'($urandom_range(0, 3)));
      mode_left = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_FULL:   rdy = 1'b1;
      RX_HALF:   rdy = 1'($urandom_range(0, 1));
      RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
      default:   rdy = ($urandom_range(0, 7) != 0);
    endcase
    m_axis_tready_i <= rdy && !rx_hold;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_pixel(input logic [31:0] word, input logic last);
    pix_req_t px;
    px.word = word;
    px.last = last;
    pixel_pending_q.push_back(px);
    n_queued++;
  endtask

  // Mostly well-formed pixels (c <= a), with zero, full and tiny alpha
  // weighted up and some malformed colour bytes mixed in.
  task automatic push_random(input int unsigned count);
    logic [7:0] a;
    logic [7:0] c[3];
    int unsigned k;
    for (int unsigned n = 0; n < count; n++) begin
      k = $urandom_range(0, 9);
      if (k == 0)      a = 8'd0;
      else if (k == 1) a = 8'hFF;
      else if (k == 2) a = 8'($urandom_range(1, 3));
      else             a = 8'($urandom_range(0, 255));
      for (int i = 0; i < 3; i++)
        c[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, a));
      push_pixel({a, c[0], c[1], c[2]}, $urandom_range(0, 7) == 0);
    end
  endtask

  // Stimulus stops here until every queued pixel has come back.
  task automatic wait_drained();
    while (n_checked != n_queued) @(posedge clk_i);
    repeat (PIPE_DEPTH + 3) @(posedge clk_i);
  endtask

  task automatic write_keep_alpha(input logic value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    keep_alpha_mirror = value;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, alpha mode from reset
    push_pixel(32'h0000_0000, 1'b0);   // all zero
    push_pixel(32'h00FF_FFFF, 1'b0);   // zero alpha with full colour -> black
    push_pixel(32'hFFFF_FFFF, 1'b1);   // opaque white
    push_pixel(32'hFF00_0000, 1'b0);   // opaque black
    push_pixel(32'hFF80_4020, 1'b0);   // opaque, divide by 255
    push_pixel(32'h0101_0101, 1'b0);   // smallest alpha, c == a
    push_pixel(32'h01FF_00FF, 1'b1);   // malformed at smallest alpha
    push_pixel(32'h80C8_FF40, 1'b0);   // malformed red and green
    push_pixel(32'h8080_8080, 1'b0);   // c == a mid range
    push_pixel(32'h8000_0001, 1'b0);
    push_pixel(32'h7F3F_1F0F, 1'b0);   // rounding around half
    push_pixel(32'h0201_0201, 1'b0);
    push_pixel(32'hFE7F_7E01, 1'b1);
    push_pixel(32'hAA55_AA55, 1'b0);
    wait_drained();

    // directed, copy mode
    write_keep_alpha(1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b1);
    push_pixel(32'h0000_0000, 1'b0);
    push_pixel(32'h00FF_FFFF, 1'b0);
    push_pixel(32'h1234_5678, 1'b0);
    push_pixel(32'h80C8_FF40, 1'b0);
    push_pixel(32'h01FF_00FF, 1'b1);
    push_pixel(32'hA5A5_A5A5, 1'b0);
    push_pixel(32'h5A5A_5A5A, 1'b1);
    wait_drained();

    write_keep_alpha(1'b1);
    push_random(600);
    wait_drained();

    write_keep_alpha(1'b0);
    push_random(400);
    wait_drained();

    // pressure: receiver held off while the sender keeps offering
    write_keep_alpha(1'b1);
    pressure_on <= 1'b1;
    push_random(500);
    wait_drained();
    pressure_on <= 1'b0;

    write_keep_alpha(1'b0);
    push_random(150);
    wait_drained();

    write_keep_alpha(1'b1);
    push_random(200);
    wait_drained();

    // anything still arriving now is flagged by the monitor
    repeat (4 * PIPE_DEPTH) @(posedge clk_i);
    if (rgba_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", rgba_expect_q.size()));
    if (err_count == 0) begin
      $display("argb32_unpremultiply_to_rgba regression: pass");
    end else begin
      $display("argb32_unpremultiply_to_rgba regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("argb32_unpremultiply_to_rgba regression: fail");
    $finish;
  end

endmodule
